@@ hw/rtl/assert_macros.svh @@
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is asserted
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked check that also holds while reset is asserted
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hw/rtl/goa_pkg.sv @@
// ----------------------------------------------------------------------------
// goa_pkg
// Shared types and constants of the goal ownership arbiter.
// ----------------------------------------------------------------------------
package goa_pkg;

    // sizes of the stored state
    localparam int HIST_DEPTH = 16;
    localparam int SOURCES    = 9;
    localparam int TAG_BITS   = 64;

    // port widths
    localparam int IO_TAG_W = 64;
    localparam int SEQ_W    = 64;
    localparam int SRC_W    = 4;
    localparam int FUNC_W   = 2;
    localparam int CODE_W   = 4;
    localparam int LIM_W    = 5;

    localparam logic [LIM_W-1:0] LIM_RESET = LIM_W'(16);

    // derived index widths
    localparam int HIST_IDX_W = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int HIST_CNT_W = $clog2(HIST_DEPTH + 1);
    localparam int SRC_IDX_W  = (SOURCES > 1) ? $clog2(SOURCES) : 1;

    // operations
    typedef enum logic [FUNC_W-1:0] {
        FN_ACQUIRE    = 2'd0,
        FN_CANCEL_REQ = 2'd1,
        FN_CANCEL_ACK = 2'd2,
        FN_COMPLETE   = 2'd3
    } func_t;

    // result codes
    typedef enum logic [CODE_W-1:0] {
        RC_ACCEPTED       = 4'd0,
        RC_INVALID        = 4'd1,
        RC_BUSY           = 4'd2,
        RC_DUPLICATE      = 4'd3,
        RC_STALE          = 4'd4,
        RC_NO_ACTIVE      = 4'd5,
        RC_MISMATCH       = 4'd6,
        RC_CANCEL_REQ     = 4'd7,
        RC_ALREADY_REQ    = 4'd8,
        RC_NOT_REQ        = 4'd9,
        RC_CANCEL_ACKED   = 4'd10,
        RC_COMPLETED      = 4'd11
    } code_t;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_EXEC
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic lookup;
        logic commit;
    } cmd_t;

endpackage

@@ hw/rtl/goal_ownership_arbiter.sv @@
// ----------------------------------------------------------------------------
// goal_ownership_arbiter
// Owns at most one active goal; arbitrates acquire, cancel request, cancel
// acknowledge and complete, with duplicate detection over the active and released goals.
//
//   channel   handshake              payload
//   command   start / busy           func goal_tag seq_number source_id goal_ok
//   result    done (one cycle)       code granted changed reported_tag
//                                    tag_present busy_now cancel_pending
//   config    cfg_we                 cfg_wdata (history_limit)
//
// A command passes a lookup state, which compares its tag across the whole
// history ring and the per-source sequence, and an exec state that commits
// the outcome. A new command may enter while the previous one commits, not
// during its lookup; done is high in the cycle after the commit.
// Reset is asynchronous and clears the goal, sequence table and history
// valid bits at once; no clearing pass.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module goal_ownership_arbiter (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [goa_pkg::FUNC_W-1:0]     func,
    input  logic [goa_pkg::IO_TAG_W-1:0]   goal_tag,
    input  logic [goa_pkg::SEQ_W-1:0]      seq_number,
    input  logic [goa_pkg::SRC_W-1:0]      source_id,
    input  logic                           goal_ok,
    input  logic                           cfg_we,
    input  logic [goa_pkg::LIM_W-1:0]      cfg_wdata,
    output logic                           done,
    output logic [goa_pkg::CODE_W-1:0]     code,
    output logic                           granted,
    output logic                           changed,
    output logic [goa_pkg::IO_TAG_W-1:0]   reported_tag,
    output logic                           tag_present,
    output logic                           busy_now,
    output logic                           cancel_pending
);
    import goa_pkg::*;

    cmd_t cmd;

    // sequencer
    goa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    // state and result datapath
    goa_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .func           (func),
        .goal_tag       (goal_tag),
        .seq_number     (seq_number),
        .source_id      (source_id),
        .goal_ok        (goal_ok),
        .code           (code),
        .granted        (granted),
        .changed        (changed),
        .reported_tag   (reported_tag),
        .tag_present    (tag_present),
        .busy_now       (busy_now),
        .cancel_pending (cancel_pending)
    );

endmodule

@@ hw/rtl/goa_ctrl.sv @@
// ----------------------------------------------------------------------------
// goa_ctrl
// Sequencer: accept a command, run the history lookup, then commit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module goa_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    output logic          done,
    output goa_pkg::cmd_t cmd
);
    import goa_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;
    logic   accept;

    // a new beat may enter in idle or while the previous one commits
    assign accept = start && !busy;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_LOOKUP;
            end
            ST_LOOKUP:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                state_next = start ? ST_LOOKUP : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        busy       = (state_reg == ST_LOOKUP);
        cmd.load   = start && (state_reg != ST_LOOKUP);
        cmd.lookup = (state_reg == ST_LOOKUP);
        cmd.commit = (state_reg == ST_EXEC);
        done_next  = (state_reg == ST_EXEC);
    end

    // state and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign done = done_reg;

    // checks
    `ASSERT_CLK(a_accept_to_lookup, accept |=> (state_reg == ST_LOOKUP), "accepted beat not looked up")
    `ASSERT_CLK(a_lookup_to_exec, (state_reg == ST_LOOKUP) |=> (state_reg == ST_EXEC), "lookup not followed by commit")
    `ASSERT_CLK(a_done_after_exec, done |-> ($past(state_reg) == ST_EXEC), "result strobe without commit")

endmodule

@@ hw/rtl/goa_datapath.sv @@
// ----------------------------------------------------------------------------
// goa_datapath
// Goal state, per-source sequence table, release history ring and result
// registers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module goa_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  goa_pkg::cmd_t                  cmd,
    input  logic                           cfg_we,
    input  logic [goa_pkg::LIM_W-1:0]      cfg_wdata,
    input  logic [goa_pkg::FUNC_W-1:0]     func,
    input  logic [goa_pkg::IO_TAG_W-1:0]   goal_tag,
    input  logic [goa_pkg::SEQ_W-1:0]      seq_number,
    input  logic [goa_pkg::SRC_W-1:0]      source_id,
    input  logic                           goal_ok,
    output logic [goa_pkg::CODE_W-1:0]     code,
    output logic                           granted,
    output logic                           changed,
    output logic [goa_pkg::IO_TAG_W-1:0]   reported_tag,
    output logic                           tag_present,
    output logic                           busy_now,
    output logic                           cancel_pending
);
    import goa_pkg::*;

    // age of ring slot idx when newest was the last slot written
    function automatic logic [HIST_IDX_W-1:0] ring_age(input logic [HIST_IDX_W-1:0] newest,
                                                       input int idx);
        int a;
        a = int'(newest) - idx;
        if (a < 0)
            a = a + HIST_DEPTH;
        return HIST_IDX_W'(a);
    endfunction

    // limit register mapped onto 1 .. HIST_DEPTH
    function automatic logic [HIST_CNT_W-1:0] eff_limit(input logic [LIM_W-1:0] lim);
        int l;
        l = int'(lim);
        if (l == 0)
            l = 1;
        else if (l > HIST_DEPTH)
            l = HIST_DEPTH;
        return HIST_CNT_W'(l);
    endfunction

    // configuration
    logic [LIM_W-1:0]      lim_reg;

    // captured beat
    func_t                 func_reg;
    logic [TAG_BITS-1:0]   tag_reg;
    logic [SEQ_W-1:0]      seq_reg;
    logic [SRC_IDX_W-1:0]  src_reg;
    logic                  ok_reg;
    logic [SRC_IDX_W-1:0]  src_map;

    // lookup results
    logic                  seen_reg;
    logic                  stale_reg;
    logic                  match_reg;
    logic                  hist_hit;

    // goal state
    logic                  active_reg;
    logic [TAG_BITS-1:0]   active_tag_reg;
    logic [SEQ_W-1:0]      active_seq_reg;
    logic                  cancel_reg;
    logic [SEQ_W-1:0]      last_seq_reg [SOURCES];

    // history ring
    logic [TAG_BITS-1:0]   hist_tag_reg [HIST_DEPTH];
    logic [HIST_DEPTH-1:0] hist_valid_reg;
    logic [HIST_DEPTH-1:0] hist_valid_next;
    logic [HIST_IDX_W-1:0] head_reg;
    logic [HIST_IDX_W-1:0] head_next;
    logic [HIST_CNT_W-1:0] cnt_reg;
    logic [HIST_CNT_W-1:0] cnt_inc;
    logic [HIST_CNT_W-1:0] cnt_next;
    logic [HIST_CNT_W-1:0] lim_eff;

    // decision
    code_t                 code_c;
    logic                  grant_c;
    logic                  acq_c;
    logic                  cset_c;
    logic                  rel_c;
    logic                  act_after;
    logic                  cancel_after;
    logic [TAG_BITS-1:0]   rep_tag_c;

    // result registers
    code_t                 code_reg;
    logic                  granted_reg;
    logic [TAG_BITS-1:0]   rep_tag_reg;
    logic                  present_reg;
    logic                  busy_now_reg;
    logic                  pending_reg;

    // configuration write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lim_reg <= LIM_RESET;
        else if (cfg_we)
            lim_reg <= cfg_wdata;
    end

    // out of range sources share slot zero
    assign src_map = ({1'b0, source_id} < (SRC_W + 1)'(SOURCES)) ? SRC_IDX_W'(source_id)
                                                                 : '0;

    // capture the beat
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func_t'(func);
            tag_reg  <= TAG_BITS'(goal_tag);
            seq_reg  <= seq_number;
            src_reg  <= src_map;
            ok_reg   <= goal_ok;
        end
    end

    // compare against every history slot
    always_comb
    begin
        hist_hit = 1'b0;
        for (int i = 0; i < HIST_DEPTH; i++)
            hist_hit = hist_hit | (hist_valid_reg[i] && (hist_tag_reg[i] == tag_reg));
    end

    // lookup stage
    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            seen_reg  <= hist_hit || (active_reg && (active_tag_reg == tag_reg));
            stale_reg <= (seq_reg <= last_seq_reg[src_reg]);
            match_reg <= (active_tag_reg == tag_reg) && (active_seq_reg == seq_reg);
        end
    end

    // decide the outcome
    always_comb
    begin
        code_c  = RC_ACCEPTED;
        grant_c = 1'b0;
        acq_c   = 1'b0;
        cset_c  = 1'b0;
        rel_c   = 1'b0;
        if (func_reg == FN_ACQUIRE)
        begin
            if (!ok_reg)
                code_c = RC_INVALID;
            else if (seen_reg)
                code_c = RC_DUPLICATE;
            else if (stale_reg)
                code_c = RC_STALE;
            else if (active_reg)
                code_c = RC_BUSY;
            else
            begin
                code_c  = RC_ACCEPTED;
                grant_c = 1'b1;
                acq_c   = 1'b1;
            end
        end
        else if (!active_reg)
            code_c = RC_NO_ACTIVE;
        else if (!match_reg)
            code_c = RC_MISMATCH;
        else if (func_reg == FN_CANCEL_REQ)
        begin
            if (cancel_reg)
                code_c = RC_ALREADY_REQ;
            else
            begin
                code_c  = RC_CANCEL_REQ;
                grant_c = 1'b1;
                cset_c  = 1'b1;
            end
        end
        else if ((func_reg == FN_CANCEL_ACK) && !cancel_reg)
            code_c = RC_NOT_REQ;
        else
        begin
            code_c  = (func_reg == FN_CANCEL_ACK) ? RC_CANCEL_ACKED : RC_COMPLETED;
            grant_c = 1'b1;
            rel_c   = 1'b1;
        end
    end

    // goal state after this beat
    always_comb
    begin
        act_after    = (active_reg || acq_c) && !rel_c;
        cancel_after = (cancel_reg || cset_c) && !rel_c && !acq_c;
        if (rel_c)
            rep_tag_c = active_tag_reg;
        else if (acq_c)
            rep_tag_c = tag_reg;
        else if (active_reg)
            rep_tag_c = active_tag_reg;
        else
            rep_tag_c = '0;
    end

    // history ring update on release, trimmed to the limit
    always_comb
    begin
        lim_eff   = eff_limit(lim_reg);
        cnt_inc   = (cnt_reg == HIST_CNT_W'(HIST_DEPTH)) ? cnt_reg : cnt_reg + 1'b1;
        cnt_next  = (cnt_inc > lim_eff) ? lim_eff : cnt_inc;
        head_next = (head_reg == HIST_IDX_W'(HIST_DEPTH - 1)) ? '0 : head_reg + 1'b1;
        for (int i = 0; i < HIST_DEPTH; i++)
            hist_valid_next[i] = HIST_CNT_W'(ring_age(head_reg, i)) < cnt_next;
    end

    // goal and history control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= 1'b0;
            active_tag_reg <= '0;
            active_seq_reg <= '0;
            cancel_reg     <= 1'b0;
            hist_valid_reg <= '0;
            head_reg       <= '0;
            cnt_reg        <= '0;
            for (int s = 0; s < SOURCES; s++)
                last_seq_reg[s] <= '0;
        end
        else if (cmd.commit)
        begin
            active_reg <= act_after;
            cancel_reg <= cancel_after;
            if (acq_c)
            begin
                active_tag_reg        <= tag_reg;
                active_seq_reg        <= seq_reg;
                last_seq_reg[src_reg] <= seq_reg;
            end
            else if (rel_c)
            begin
                active_tag_reg <= '0;
                active_seq_reg <= '0;
                hist_valid_reg <= hist_valid_next;
                head_reg       <= head_next;
                cnt_reg        <= cnt_next;
            end
        end
    end

    // history tag storage
    always_ff @(posedge clk)
    begin
        if (cmd.commit && rel_c)
            hist_tag_reg[head_reg] <= active_tag_reg;
    end

    // result registers
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            code_reg     <= code_c;
            granted_reg  <= grant_c;
            rep_tag_reg  <= rep_tag_c;
            present_reg  <= rel_c || act_after;
            busy_now_reg <= act_after;
            pending_reg  <= act_after && cancel_after;
        end
    end

    assign code           = code_reg;
    assign granted        = granted_reg;
    assign changed        = granted_reg;
    assign reported_tag   = IO_TAG_W'(rep_tag_reg);
    assign tag_present    = present_reg;
    assign busy_now       = busy_now_reg;
    assign cancel_pending = pending_reg;

    // checks
    `ASSERT_CLK(a_valid_matches_count, $countones(hist_valid_reg) == int'(cnt_reg), "history valid bits disagree with fill count")
    `ASSERT_CLK(a_cancel_needs_goal, cancel_reg |-> active_reg, "cancel flag set with no active goal")
    `ASSERT_CLK(a_release_clears_goal, (cmd.commit && rel_c) |=> (!active_reg && !cancel_reg), "release left a goal active")

endmodule

@@ bench/tb_goal_ownership_arbiter.sv @@
// ----------------------------------------------------------------------------
// tb_goal_ownership_arbiter
// Self-checking bench for the goal ownership arbiter. A directed opening
// walks every operation and result code, then random phases under a range of
// history limits mix well-formed goal lifecycles with broken ones and noise.
// Every result beat is checked against a predicted result in arrival order.
// ----------------------------------------------------------------------------
module tb_goal_ownership_arbiter;

    import goa_pkg::*;

    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 185;

    // one result beat, kept as logic so that unknowns show up
    typedef struct packed {
        logic [CODE_W-1:0]   code;
        logic                granted;
        logic                changed;
        logic [IO_TAG_W-1:0] tag;
        logic                present;
        logic                active;
        logic                cancel;
    } goal_result_t;

    // predicted arbiter state and the queue of results still to come
    class goal_scoreboard;
        logic [LIM_W-1:0]  hist_limit;
        bit                goal_live;
        bit [TAG_BITS-1:0] live_tag;
        bit [SEQ_W-1:0]    live_seq;
        bit                cancel_asked;
        bit [SEQ_W-1:0]    newest_seq [SOURCES];
        bit [TAG_BITS-1:0] ring_tag [HIST_DEPTH];
        bit                ring_used [HIST_DEPTH];
        int                ring_head;
        int                ring_fill;
        goal_result_t      result_q [$];
        int                n_checked;
        int                n_errors;
        int                code_hits [12];

        function new();
            hist_limit   = LIM_RESET;
            goal_live    = 1'b0;
            live_tag     = '0;
            live_seq     = '0;
            cancel_asked = 1'b0;
            ring_head    = 0;
            ring_fill    = 0;
            n_checked    = 0;
            n_errors     = 0;
            foreach (newest_seq[i]) newest_seq[i] = '0;
            foreach (ring_used[i]) ring_used[i] = 1'b0;
            foreach (ring_tag[i]) ring_tag[i] = '0;
            foreach (code_hits[i]) code_hits[i] = 0;
        endfunction

        function void set_limit(logic [LIM_W-1:0] v);
            hist_limit = v;
        endfunction

        function int pending();
            return result_q.size();
        endfunction

        // work out the result of one accepted command beat
        function void note_command(func_t op, logic [IO_TAG_W-1:0] tag_in,
                                   logic [SEQ_W-1:0] seq, logic [SRC_W-1:0] src_in,
                                   logic ok);
            bit [TAG_BITS-1:0] tag;
            int                slot;
            int                lim;
            int                oldest;
            int                i;
            bit                seen;
            bit                released;
            goal_result_t      r;
            tag      = tag_in[TAG_BITS-1:0];
            slot     = (src_in >= SOURCES) ? 0 : int'(src_in);
            released = 1'b0;
            r        = '0;
            // tag lookup across the live goal and the history ring
            seen = goal_live && (live_tag == tag);
            for (i = 0; i < HIST_DEPTH; i++)
                if (ring_used[i] && ring_tag[i] == tag) seen = 1'b1;
            if (op == FN_ACQUIRE) begin
                if (!ok) r.code = RC_INVALID;
                else if (seen) r.code = RC_DUPLICATE;
                else if (seq <= newest_seq[slot]) r.code = RC_STALE;
                else if (goal_live) r.code = RC_BUSY;
                else
                begin
                    goal_live        = 1'b1;
                    live_tag         = tag;
                    live_seq         = seq;
                    cancel_asked     = 1'b0;
                    newest_seq[slot] = seq;
                    r.code           = RC_ACCEPTED;
                    r.granted        = 1'b1;
                end
            end
            else if (!goal_live) r.code = RC_NO_ACTIVE;
            else if (live_tag != tag || live_seq != seq) r.code = RC_MISMATCH;
            else if (op == FN_CANCEL_REQ) begin
                if (cancel_asked) r.code = RC_ALREADY_REQ;
                else
                begin
                    cancel_asked = 1'b1;
                    r.code       = RC_CANCEL_REQ;
                    r.granted    = 1'b1;
                end
            end
            else if (op == FN_CANCEL_ACK && !cancel_asked) r.code = RC_NOT_REQ;
            else
            begin
                // release: push into the ring, then trim down to the limit
                r.code    = (op == FN_CANCEL_ACK) ? RC_CANCEL_ACKED : RC_COMPLETED;
                r.granted = 1'b1;
                r.tag     = live_tag;
                r.present = 1'b1;
                released  = 1'b1;
                if (hist_limit == 0) lim = 1;
                else if (hist_limit > HIST_DEPTH) lim = HIST_DEPTH;
                else lim = int'(hist_limit);
                ring_tag[ring_head]  = live_tag;
                ring_used[ring_head] = 1'b1;
                ring_head            = (ring_head + 1) % HIST_DEPTH;
                if (ring_fill < HIST_DEPTH) ring_fill++;
                while (ring_fill > lim) begin
                    oldest            = (ring_head + HIST_DEPTH - ring_fill) % HIST_DEPTH;
                    ring_used[oldest] = 1'b0;
                    ring_fill--;
                end
                goal_live    = 1'b0;
                cancel_asked = 1'b0;
                live_tag     = '0;
                live_seq     = '0;
            end
            r.changed = r.granted;
            if (!released && goal_live) begin
                r.tag     = live_tag;
                r.present = 1'b1;
            end
            r.active = goal_live;
            r.cancel = goal_live && cancel_asked;
            result_q.insert(result_q.size(), r);
        endfunction

        // compare one result beat with the oldest prediction
        function void check_result(goal_result_t got);
            goal_result_t want;
            if (result_q.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("result beat with nothing expected: code %0d tag %h",
                             got.code, got.tag);
                return;
            end
            want = result_q[0];
            result_q.delete(0);
            n_checked++;
            if (want.code <= RC_COMPLETED) code_hits[want.code]++;
            if (got.code !== want.code || got.granted !== want.granted ||
                got.changed !== want.changed || got.tag !== want.tag ||
                got.present !== want.present || got.active !== want.active ||
                got.cancel !== want.cancel) begin
                n_errors++;
                if (n_errors <= 10) begin
                    $display("mismatch on result %0d (expected / actual):", n_checked);
                    $display("  code %0d/%0d granted %b/%b changed %b/%b present %b/%b",
                             want.code, got.code, want.granted, got.granted,
                             want.changed, got.changed, want.present, got.present);
                    $display("  tag %h/%h busy_now %b/%b cancel_pending %b/%b",
                             want.tag, got.tag, want.active, got.active,
                             want.cancel, got.cancel);
                end
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [FUNC_W-1:0]   func = '0;
    logic [IO_TAG_W-1:0] goal_tag = '0;
    logic [SEQ_W-1:0]    seq_number = '0;
    logic [SRC_W-1:0]    source_id = '0;
    logic                goal_ok = 1'b0;
    logic                cfg_we = 1'b0;
    logic [LIM_W-1:0]    cfg_wdata = '0;
    logic                done;
    logic [CODE_W-1:0]   code;
    logic                granted;
    logic                changed;
    logic [IO_TAG_W-1:0] reported_tag;
    logic                tag_present;
    logic                busy_now;
    logic                cancel_pending;

    goal_scoreboard      sb = new();
    logic [IO_TAG_W-1:0] used_tags [$];
    int                  idle_pct = 28;

    goal_ownership_arbiter dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .func           (func),
        .goal_tag       (goal_tag),
        .seq_number     (seq_number),
        .source_id      (source_id),
        .goal_ok        (goal_ok),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .done           (done),
        .code           (code),
        .granted        (granted),
        .changed        (changed),
        .reported_tag   (reported_tag),
        .tag_present    (tag_present),
        .busy_now       (busy_now),
        .cancel_pending (cancel_pending)
    );

    // clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 0;
    end

    // result beats are taken at the edge that ends their cycle
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
            sb.check_result({code, granted, changed, reported_tag, tag_present,
                             busy_now, cancel_pending});
    end

    // run limit
    initial
    begin
        #8_000_000;
        $display("goal_ownership_arbiter test failed");
        $finish;
    end

    // sequence slot a source lands in
    function automatic int seq_slot(logic [SRC_W-1:0] s);
        return (s >= SOURCES) ? 0 : int'(s);
    endfunction

    // drive one command beat, with an optional gap first, until accepted
    task automatic issue(func_t op, logic [IO_TAG_W-1:0] t, logic [SEQ_W-1:0] s,
                         logic [SRC_W-1:0] src, logic ok);
        int gap;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            gap = $urandom_range(1, 3);
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        func       <= op;
        goal_tag   <= t;
        seq_number <= s;
        source_id  <= src;
        goal_ok    <= ok;
        do @(posedge clk); while (busy !== 1'b0);
        sb.note_command(op, t, s, src, ok);
        if (op == FN_ACQUIRE) begin
            used_tags.insert(used_tags.size(), t);
            if (used_tags.size() > 40) used_tags.delete(0);
        end
    endtask

    // stop sending and let outstanding results drain
    task automatic wait_idle();
        int w;
        start <= 1'b0;
        for (w = 0; w < 200 && sb.pending() != 0; w++) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    initial
    begin
        int                  p;
        int                  n;
        int                  pick;
        int                  codes_seen;
        logic [SRC_W-1:0]    src;
        logic [IO_TAG_W-1:0] tag;
        logic [SEQ_W-1:0]    seq;
        func_t               op;
        logic [LIM_W-1:0]    limit_plan [PHASES];

        limit_plan = '{5'd0, 5'd1, 5'd31, 5'd3, 5'd16, 5'd17, 5'd7, 5'd2, 5'd12, 5'd5};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed opening at the reset limit
        issue(FN_COMPLETE, 64'd7, 64'd1, 4'd0, 1'b1);                 // nothing active
        issue(FN_CANCEL_REQ, 64'd7, 64'd1, 4'd2, 1'b0);
        issue(FN_ACQUIRE, 64'd9, 64'd3, 4'd1, 1'b0);                  // invalid
        issue(FN_ACQUIRE, 64'd0, 64'd0, 4'd1, 1'b1);                  // stale at zero
        issue(FN_ACQUIRE, '1, 64'd1, 4'd15, 1'b1);                    // out of range source
        issue(FN_ACQUIRE, '1, 64'd2, 4'd2, 1'b1);                     // duplicate while busy
        issue(FN_ACQUIRE, 64'd5, 64'd1, 4'd0, 1'b1);                  // stale via aliased slot
        issue(FN_ACQUIRE, 64'd5, 64'd1, 4'd3, 1'b1);                  // busy
        issue(FN_CANCEL_ACK, '1, 64'd1, 4'd3, 1'b0);                  // not requested
        issue(FN_CANCEL_REQ, '1, 64'd2, 4'd3, 1'b1);                  // seq mismatch
        issue(FN_CANCEL_REQ, 64'hFFFF_FFFF_FFFF_FFFE, 64'd1, 4'd3, 1'b1);
        issue(FN_CANCEL_REQ, '1, 64'd1, 4'd4, 1'b1);
        issue(FN_CANCEL_REQ, '1, 64'd1, 4'd4, 1'b1);                  // already requested
        issue(FN_COMPLETE, '1, 64'd1, 4'd4, 1'b0);                    // complete with cancel up
        issue(FN_ACQUIRE, '1, 64'd5, 4'd4, 1'b1);                     // duplicate from history
        issue(FN_ACQUIRE, '1, 64'd5, 4'd4, 1'b0);                     // invalid beats duplicate
        issue(FN_ACQUIRE, 64'd0, '1, 4'd8, 1'b1);                     // tag zero is a real goal
        issue(FN_CANCEL_REQ, 64'd0, '1, 4'd8, 1'b1);
        issue(FN_CANCEL_ACK, 64'd0, '1, 4'd8, 1'b1);
        issue(FN_ACQUIRE, 64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFE, 4'd5, 1'b1);
        issue(FN_COMPLETE, 64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFE, 4'd5, 1'b1);
        issue(FN_CANCEL_ACK, 64'd0, 64'd0, 4'd5, 1'b1);               // nothing active

        // random phases, one history limit each
        for (p = 0; p < PHASES; p++) begin
            wait_idle();
            cfg_we    <= 1'b1;
            cfg_wdata <= limit_plan[p];
            @(posedge clk);
            sb.set_limit(limit_plan[p]);
            cfg_we    <= 1'b0;
            idle_pct  = (p == 3) ? 0 : 28;

            for (n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                do src = $urandom_range(0, 15);
                while (sb.newest_seq[seq_slot(src)] > 64'hFFFF_FFFF_FF00_0000);
                seq = sb.newest_seq[seq_slot(src)] + $urandom_range(1, 300);
                if ($urandom_range(0, 3) == 0) tag = $urandom_range(1, 48);
                else tag = {$urandom, $urandom};

                if (pick < 62) begin
                    // well-formed lifecycle driven by the predicted goal
                    if (!sb.goal_live) issue(FN_ACQUIRE, tag, seq, src, 1'b1);
                    else
                    begin
                        case ($urandom_range(0, 9))
                            0, 1, 2:    op = FN_COMPLETE;
                            3, 4, 5, 6: op = FN_CANCEL_REQ;
                            default:    op = FN_CANCEL_ACK;
                        endcase
                        issue(op, sb.live_tag, sb.live_seq, src, 1'($urandom_range(0, 1)));
                    end
                end
                else if (pick < 82) begin
                    // broken sequences
                    op = func_t'($urandom_range(1, 3));
                    case ($urandom_range(0, 5))
                        0: issue(FN_ACQUIRE, tag, seq, src, 1'b0);
                        1: begin
                            if (used_tags.size() != 0)
                                tag = used_tags[$urandom_range(0, used_tags.size() - 1)];
                            issue(FN_ACQUIRE, tag, seq, src, 1'b1);
                        end
                        2: begin
                            seq = sb.newest_seq[seq_slot(src)];
                            if (seq != 0) seq = seq - $urandom_range(0, 1);
                            issue(FN_ACQUIRE, tag, seq, src, 1'b1);
                        end
                        3: issue(FN_ACQUIRE, tag, seq, src, 1'b1);
                        4: issue(op, sb.live_tag, sb.live_seq ^ (64'd1 << $urandom_range(0, 63)),
                                 src, 1'b1);
                        default: issue(op, sb.live_tag ^ (64'd1 << $urandom_range(0, 63)),
                                       sb.live_seq, src, 1'b1);
                    endcase
                end
                else
                begin
                    // noise over the whole field ranges
                    op = func_t'($urandom_range(0, 3));
                    if ($urandom_range(0, 1) == 0) tag = {$urandom, $urandom};
                    else if (sb.goal_live) tag = sb.live_tag;
                    if ($urandom_range(0, 2) == 0) seq = {$urandom, $urandom};
                    else if (sb.goal_live && op != FN_ACQUIRE) seq = sb.live_seq;
                    issue(op, tag, seq, src, 1'($urandom_range(0, 1)));
                end
            end
        end

        // drain and report
        wait_idle();
        if (sb.pending() != 0) begin
            $display("%0d expected results never arrived", sb.pending());
            sb.n_errors += sb.pending();
        end
        codes_seen = 0;
        foreach (sb.code_hits[i]) if (sb.code_hits[i] != 0) codes_seen++;
        $display("%0d results checked over %0d history limit settings, %0d of 12 codes hit",
                 sb.n_checked, PHASES + 1, codes_seen);
        $display("%0d failures", sb.n_errors);
        if (sb.n_errors == 0)
            $display("goal_ownership_arbiter test passed");
        else
            $display("goal_ownership_arbiter test failed");
        $finish;
    end

endmodule
